// ===== rtl/vtsa_pkg.sv =====
// Package for the video timing and scroll address unit.
// Holds the item mode codes, frame timing constants and the tick event struct.
// No dependencies.
package vtsa_pkg;

  // Item modes
  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_CTRL   = 3'd1,
    MODE_MASK   = 3'd2,
    MODE_SCROLL = 3'd3,
    MODE_ADDR   = 3'd4,
    MODE_DATA   = 3'd5,
    MODE_STATUS = 3'd6,
    MODE_POLL   = 3'd7
  } mode_e;

  // Frame timing
  localparam logic [8:0] DOT_RESET      = 9'd20;
  localparam logic [8:0] DOT_LAST       = 9'd340;   // 341 dots per line
  localparam logic [8:0] LINE_PRE       = 9'h1FF;   // prerender line, -1
  localparam logic [8:0] LINE_VISIBLE   = 9'd240;
  localparam logic [8:0] LINE_VBLANK    = 9'd241;
  localparam logic [8:0] LINE_LAST      = 9'd260;   // next line wraps to prerender
  localparam logic [8:0] DOT_FETCH_LO   = 9'd2;
  localparam logic [8:0] DOT_FETCH_HI   = 9'd258;
  localparam logic [8:0] DOT_PREF_LO    = 9'd321;
  localparam logic [8:0] DOT_PREF_HI    = 9'd338;
  localparam logic [8:0] DOT_FINE_Y     = 9'd256;
  localparam logic [8:0] DOT_COPY_H     = 9'd257;
  localparam logic [8:0] DOT_COPY_V_LO  = 9'd280;
  localparam logic [8:0] DOT_COPY_V_HI  = 9'd305;

  // Scroll address layout
  localparam logic [4:0]  COARSE_Y_WRAP = 5'd29;
  localparam logic [14:0] COPY_H_MASK   = 15'h041F;
  localparam logic [14:0] COPY_V_MASK   = 15'h7BE0;

  // Events raised by one tick
  typedef struct packed {
    logic col_step;    // step the tile column
    logic fine_y;      // step fine Y
    logic copy_h;      // horizontal copy from temp address
    logic copy_v;      // vertical copy from temp address
    logic vbl_set;     // enter vblank, new frame
    logic vbl_clear;   // prerender dot 1 clears vblank
    logic frame_end;   // wrap to prerender line
  } tick_evt_t;

endpackage

// ===== rtl/vtsa_timing.sv =====
// Dot and scanline counters with the odd frame skip.
// Decodes the per-tick scroll and vblank events. Depends on vtsa_pkg.
module vtsa_timing import vtsa_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tick_en_i,
  input  logic       rend_i,
  output tick_evt_t  evt_o,
  output logic [8:0] dot_next_o,
  output logic [8:0] line_next_o
);

  logic [8:0] dot_q, dot_d;
  logic [8:0] line_q, line_d;
  logic       even_q, even_d;
  logic [8:0] dot_eff;
  logic [8:0] dot_inc;
  logic       active_line;
  logic       fetch_dot;

  // Decode events for the current position
  always_comb begin
    evt_o       = '0;
    active_line = (line_q == LINE_PRE) || (line_q < LINE_VISIBLE);
    dot_eff     = dot_q;
    if (active_line && even_q && rend_i && (line_q == 9'd0) && (dot_q == 9'd0)) begin
      dot_eff = 9'd1;
    end
    fetch_dot = ((dot_eff >= DOT_FETCH_LO) && (dot_eff < DOT_FETCH_HI)) ||
                ((dot_eff >= DOT_PREF_LO) && (dot_eff < DOT_PREF_HI));
    if (tick_en_i && active_line) begin
      evt_o.vbl_clear = (line_q == LINE_PRE) && (dot_eff == 9'd1);
      if (rend_i) begin
        evt_o.col_step = fetch_dot && (dot_eff[2:0] == 3'd0);
        evt_o.fine_y   = (dot_eff == DOT_FINE_Y);
        evt_o.copy_h   = (dot_eff == DOT_COPY_H);
        evt_o.copy_v   = (line_q == LINE_PRE) && (dot_eff >= DOT_COPY_V_LO) &&
                         (dot_eff < DOT_COPY_V_HI);
      end
    end
    evt_o.vbl_set   = tick_en_i && (line_q == LINE_VBLANK) && (dot_eff == 9'd1);
    evt_o.frame_end = tick_en_i && (dot_eff == DOT_LAST) && (line_q == LINE_LAST);
  end

  // Advance dot and line
  always_comb begin
    dot_d   = dot_q;
    line_d  = line_q;
    even_d  = even_q;
    dot_inc = dot_eff + 9'd1;
    if (tick_en_i) begin
      if (dot_eff == DOT_LAST) begin
        dot_d = 9'd0;
        if (line_q == LINE_LAST) begin
          line_d = LINE_PRE;
          even_d = ~even_q;
        end else begin
          line_d = line_q + 9'd1;
        end
      end else begin
        dot_d = dot_inc;
      end
    end
  end

  assign dot_next_o  = dot_d;
  assign line_next_o = line_d;

  // Hold position state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q  <= DOT_RESET;
      line_q <= 9'd0;
      even_q <= 1'b0;
    end else begin
      dot_q  <= dot_d;
      line_q <= line_d;
      even_q <= even_d;
    end
  end

  a_dot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dot_q <= DOT_LAST)
    else $error("dot counter out of range");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_o.frame_end |=> (line_q == LINE_PRE) && (dot_q == 9'd0))
    else $error("frame end did not wrap to prerender");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tick_en_i |=> $stable(dot_q) && $stable(line_q))
    else $error("position moved without a tick");

  a_scroll_rend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (evt_o.col_step || evt_o.fine_y || evt_o.copy_h || evt_o.copy_v) |-> rend_i)
    else $error("scroll event while rendering off");

endmodule

// ===== rtl/video_timing_and_scroll_address_unit.sv =====
// Top level of the video timing and scroll address unit.
// Holds flags, write latch, scroll addresses and the item pipeline.
// Depends on vtsa_pkg and vtsa_timing.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+-----------------------------------
//   input   | in        | in_valid_i / in_ready_o  | mode_i, value_i
//   result  | out       | out_valid_o / out_ready_i| vram_address_o, status_byte_o,
//           |           |                          | nmi_flag_o, new_frame_o,
//           |           |                          | dot_position_o, line_position_o
//
// One item per cycle while the result side does not stall: an accepted item
// sits in the input register, its state update and result are computed there
// and the result is written to the output register.
// A stalled result holds the output register; the input register then holds
// its item and in_ready_o drops once both are full. Reset puts the dot at 20,
// line 0, vblank set, other state clear; payload and result registers not reset.
module video_timing_and_scroll_address_unit import vtsa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] vram_address_o,
  output logic [7:0]  status_byte_o,
  output logic        nmi_flag_o,
  output logic        new_frame_o,
  output logic [8:0]  dot_position_o,
  output logic [9:0]  line_position_o
);

  // Input register
  logic        s_valid_q;
  mode_e       s_mode_q;
  logic [7:0]  s_value_q;
  logic        advance;

  // Block state
  logic        vblank_q, vblank_d;
  logic        nmi_pend_q, nmi_pend_d;
  logic        second_q, second_d;
  logic [14:0] temp_q, temp_d;
  logic [14:0] cur_q, cur_d;
  logic [2:0]  fine_x_q, fine_x_d;
  logic [7:0]  ctrl_q, ctrl_d;
  logic [7:0]  mask_q, mask_d;

  // Result register
  logic        out_valid_q;
  logic [14:0] res_addr_q, res_addr_d;
  logic [7:0]  res_status_q, res_status_d;
  logic        res_nmi_q, res_nmi_d;
  logic        res_frame_q;
  logic [8:0]  res_dot_q;
  logic [9:0]  res_line_q;

  tick_evt_t   evt;
  logic        tick_en;
  logic        rend;
  logic [8:0]  dot_next;
  logic [8:0]  line_next;
  logic [14:0] cur_cx;
  logic [14:0] cur_fy;

  function automatic logic [14:0] next_col(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[4:0] == 5'h1F) begin
      r[4:0] = 5'd0;
      r[10]  = ~v[10];
    end else begin
      r = v + 15'd1;
    end
    return r;
  endfunction

  function automatic logic [14:0] step_fine_y(input logic [14:0] v);
    logic [14:0] r;
    r = v;
    if (v[14:12] != 3'd7) begin
      r[14:12] = v[14:12] + 3'd1;
    end else begin
      r[14:12] = 3'd0;
      if (v[9:5] == COARSE_Y_WRAP) begin
        r[9:5] = 5'd0;
        r[11]  = ~v[11];
      end else if (v[9:5] == 5'h1F) begin
        r[9:5] = 5'd0;
      end else begin
        r[9:5] = v[9:5] + 5'd1;
      end
    end
    return r;
  endfunction

  // Pipeline handshake
  assign advance    = s_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s_valid_q || advance;
  assign tick_en    = advance && (s_mode_q == MODE_TICK);
  assign rend       = mask_q[4] || mask_q[3];

  vtsa_timing u_timing (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_en_i   (tick_en),
    .rend_i      (rend),
    .evt_o       (evt),
    .dot_next_o  (dot_next),
    .line_next_o (line_next)
  );

  // Apply scroll steps in model order
  assign cur_cx = evt.col_step ? next_col(cur_q) : cur_q;
  assign cur_fy = evt.fine_y ? step_fine_y(cur_cx) : cur_cx;

  // Compute next state and result for the item in the input register
  always_comb begin
    vblank_d     = vblank_q;
    nmi_pend_d   = nmi_pend_q;
    second_d     = second_q;
    temp_d       = temp_q;
    cur_d        = cur_q;
    fine_x_d     = fine_x_q;
    ctrl_d       = ctrl_q;
    mask_d       = mask_q;
    res_addr_d   = '0;
    res_status_d = '0;
    res_nmi_d    = 1'b0;
    if (advance) begin
      case (s_mode_q)
        MODE_TICK: begin
          cur_d = cur_fy;
          if (evt.copy_h) begin
            cur_d = (cur_fy & ~COPY_H_MASK) | (temp_q & COPY_H_MASK);
          end
          if (evt.copy_v) begin
            cur_d = (cur_fy & ~COPY_V_MASK) | (temp_q & COPY_V_MASK);
          end
          if (evt.vbl_clear) begin
            vblank_d = 1'b0;
          end
          if (evt.vbl_set) begin
            vblank_d = 1'b1;
            if (ctrl_q[7]) begin
              nmi_pend_d = 1'b1;
            end
          end
          if (evt.frame_end) begin
            vblank_d   = 1'b0;
            nmi_pend_d = 1'b0;
          end
        end
        MODE_CTRL: begin
          temp_d[11:10] = s_value_q[1:0];
          ctrl_d        = s_value_q;
          if (!ctrl_q[7] && s_value_q[7] && vblank_q) begin
            nmi_pend_d = 1'b1;
          end
        end
        MODE_MASK: begin
          mask_d = s_value_q;
        end
        MODE_SCROLL: begin
          if (second_q) begin
            temp_d[14:12] = s_value_q[2:0];
            temp_d[9:5]   = s_value_q[7:3];
          end else begin
            fine_x_d    = s_value_q[2:0];
            temp_d[4:0] = s_value_q[7:3];
          end
          second_d = ~second_q;
        end
        MODE_ADDR: begin
          if (second_q) begin
            temp_d = {temp_q[14:8], s_value_q};
            cur_d  = {temp_q[14:8], s_value_q};
          end else begin
            temp_d = {1'b0, s_value_q[5:0], temp_q[7:0]};
          end
          second_d = ~second_q;
        end
        MODE_DATA: begin
          res_addr_d = cur_q;
          cur_d      = cur_q + (ctrl_q[2] ? 15'd32 : 15'd1);
        end
        MODE_STATUS: begin
          res_status_d = {vblank_q, 7'd0};
          vblank_d     = 1'b0;
          second_d     = 1'b0;
        end
        MODE_POLL: begin
          res_nmi_d  = nmi_pend_q;
          nmi_pend_d = 1'b0;
        end
        default: begin
          res_nmi_d = 1'b0;
        end
      endcase
    end
  end

  // Hold control state and the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      vblank_q    <= 1'b1;
      nmi_pend_q  <= 1'b0;
      second_q    <= 1'b0;
      temp_q      <= '0;
      cur_q       <= '0;
      fine_x_q    <= '0;
      ctrl_q      <= '0;
      mask_q      <= '0;
    end else begin
      if (in_ready_o) begin
        s_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      vblank_q   <= vblank_d;
      nmi_pend_q <= nmi_pend_d;
      second_q   <= second_d;
      temp_q     <= temp_d;
      cur_q      <= cur_d;
      fine_x_q   <= fine_x_d;
      ctrl_q     <= ctrl_d;
      mask_q     <= mask_d;
    end
  end

  // Capture item payload and results
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s_mode_q  <= mode_e'(mode_i);
      s_value_q <= value_i;
    end
    if (advance) begin
      res_addr_q   <= res_addr_d;
      res_status_q <= res_status_d;
      res_nmi_q    <= res_nmi_d;
      res_frame_q  <= evt.vbl_set;
      res_dot_q    <= dot_next;
      res_line_q   <= (line_next == LINE_PRE) ? 10'h3FF : {1'b0, line_next};
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vram_address_o  = res_addr_q;
  assign status_byte_o   = res_status_q;
  assign nmi_flag_o      = res_nmi_q;
  assign new_frame_o     = res_frame_q;
  assign dot_position_o  = res_dot_q;
  assign line_position_o = res_line_q;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for video_timing_and_scroll_address_unit.
// Drives random and directed items, predicts each result in place, compares in order.
// Depends on vtsa_pkg (mode codes) and the top-level RTL.
module tb;
  import vtsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DOTS       = 341;
  localparam int LINES      = 262;
  localparam int FRAME_SPAN = DOTS * LINES;
  localparam int BATCH      = 64;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] value;
  } cpu_item_t;

  typedef struct packed {
    logic [14:0] vram_address;
    logic [7:0]  status_byte;
    logic        nmi_flag;
    logic        new_frame;
    logic [8:0]  dot_position;
    logic [9:0]  line_position;
  } scan_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [2:0]  in_mode = 3'd0;
  logic [7:0]  in_value = 8'd0;
  logic        out_ready = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [14:0] vram_address;
  logic [7:0]  status_byte;
  logic        nmi_flag;
  logic        new_frame;
  logic [8:0]  dot_position;
  logic [9:0]  line_position;

  // Stimulus control
  cpu_item_t    pending_items[$];
  scan_result_t awaited_results[$];
  int  pushed_count = 0;
  int  accepted_count = 0;
  int  err_count = 0;
  int  checked_count = 0;
  int  tick_count = 0;
  int  data_count = 0;
  int  frames_seen = 0;
  int  nmi_seen = 0;
  int  send_gap = 0;
  int  recv_gap = 0;
  bit  quiet = 1'b0;
  bit  stall_go = 1'b0;
  logic hold_off = 1'b0;

  // Scan state of the predictor, at reset values
  logic [8:0]  dot_cnt = 9'd20;
  logic [8:0]  line_cnt = 9'd0;
  logic        skip_armed = 1'b0;
  logic        vbl = 1'b1;
  logic        nmi_pend = 1'b0;
  logic        wr_latch = 1'b0;
  logic [14:0] t_addr = 15'd0;
  logic [14:0] v_addr = 15'd0;
  logic [2:0]  fine_x = 3'd0;
  logic [7:0]  ctrl_r = 8'd0;
  logic [7:0]  mask_r = 8'd0;

  video_timing_and_scroll_address_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .mode_i         (in_mode),
    .value_i        (in_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .vram_address_o (vram_address),
    .status_byte_o  (status_byte),
    .nmi_flag_o     (nmi_flag),
    .new_frame_o    (new_frame),
    .dot_position_o (dot_position),
    .line_position_o(line_position)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int scan_line();
    return (line_cnt == 9'h1FF) ? -1 : int'(line_cnt);
  endfunction

  function automatic int pos_index(int ln, int dt);
    return (ln + 1) * DOTS + dt;
  endfunction

  // Advance the dot counter by one tick; return 1 on entering vblank
  function automatic logic scan_tick();
    int   ln;
    int   dt;
    logic rend;
    logic fresh;
    logic [2:0] fy;
    logic [4:0] cy;
    ln    = scan_line();
    dt    = dot_cnt;
    rend  = (mask_r[3] | mask_r[4]);
    fresh = 1'b0;
    if (ln < 240) begin
      // drop dot 0 of line 0 on every other frame while rendering
      if (skip_armed && rend && ln == 0 && dt == 0) dt = 1;
      if (ln == -1 && dt == 1) vbl = 1'b0;
      if (rend) begin
        if (((dt >= 2 && dt < 258) || (dt >= 321 && dt < 338)) && (dt % 8) == 0) begin
          if (v_addr[4:0] == 5'd31) begin
            v_addr[4:0] = 5'd0;
            v_addr[10]  = ~v_addr[10];
          end else begin
            v_addr[4:0] = v_addr[4:0] + 5'd1;
          end
        end
        if (dt == 256) begin
          fy = v_addr[14:12];
          cy = v_addr[9:5];
          if (fy != 3'd7) begin
            v_addr[14:12] = fy + 3'd1;
          end else begin
            v_addr[14:12] = 3'd0;
            if (cy == 5'd29) begin
              cy         = 5'd0;
              v_addr[11] = ~v_addr[11];
            end else if (cy == 5'd31) begin
              cy = 5'd0;
            end else begin
              cy = cy + 5'd1;
            end
            v_addr[9:5] = cy;
          end
        end
        if (dt == 257) v_addr = (v_addr & ~15'h041F) | (t_addr & 15'h041F);
        if (ln == -1 && dt >= 280 && dt < 305)
          v_addr = (v_addr & ~15'h7BE0) | (t_addr & 15'h7BE0);
      end
    end
    if (ln == 241 && dt == 1) begin
      fresh = 1'b1;
      vbl   = 1'b1;
      if (ctrl_r[7]) nmi_pend = 1'b1;
    end
    // step the dot, wrap line and frame
    dt = dt + 1;
    if (dt >= DOTS) begin
      dt = 0;
      ln = ln + 1;
      if (ln >= LINES - 1) begin
        skip_armed = ~skip_armed;
        ln         = -1;
        vbl        = 1'b0;
        nmi_pend   = 1'b0;
      end
    end
    dot_cnt  = 9'(dt);
    line_cnt = (ln < 0) ? 9'h1FF : 9'(ln);
    return fresh;
  endfunction

  // Apply one item to the scan state and return the result it yields
  function automatic scan_result_t next_scan_result(mode_e m, logic [7:0] v);
    scan_result_t r;
    logic was_on;
    r = '0;
    case (m)
      MODE_TICK: r.new_frame = scan_tick();
      MODE_CTRL: begin
        was_on        = ctrl_r[7];
        t_addr[11:10] = v[1:0];
        ctrl_r        = v;
        if (!was_on && v[7] && vbl) nmi_pend = 1'b1;
      end
      MODE_MASK: mask_r = v;
      MODE_SCROLL: begin
        if (wr_latch) begin
          t_addr[14:12] = v[2:0];
          t_addr[9:5]   = v[7:3];
        end else begin
          fine_x      = v[2:0];
          t_addr[4:0] = v[7:3];
        end
        wr_latch = ~wr_latch;
      end
      MODE_ADDR: begin
        if (wr_latch) begin
          t_addr[7:0] = v;
          v_addr      = t_addr;
        end else begin
          t_addr[14:8] = {1'b0, v[5:0]};
        end
        wr_latch = ~wr_latch;
      end
      MODE_DATA: begin
        r.vram_address = v_addr;
        v_addr = v_addr + (ctrl_r[2] ? 15'd32 : 15'd1);
      end
      MODE_STATUS: begin
        r.status_byte = {vbl, 7'd0};
        vbl      = 1'b0;
        wr_latch = 1'b0;
      end
      default: begin
        r.nmi_flag = nmi_pend;
        nmi_pend   = 1'b0;
      end
    endcase
    r.dot_position  = dot_cnt;
    r.line_position = (line_cnt == 9'h1FF) ? 10'h3FF : {1'b0, line_cnt};
    return r;
  endfunction

  // Present items from the queue, hold each one until taken
  always @(posedge clk) begin : feed
    cpu_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        in_valid <= 1'b0;
        send_gap <= $urandom_range(0, 9);
      end else if (pending_items.size() != 0) begin
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        in_mode  <= nxt.mode;
        in_value <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Throttle the result side in random bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_gap != 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else if (!quiet && $urandom_range(0, 15) == 0) begin
      out_ready <= 1'b0;
      recv_gap  <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Hold the result side off long enough to back up the input
  initial begin : hold_stretch
    wait (stall_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Check each result against the oldest prediction, predict each accepted item
  always @(posedge clk) begin : watch
    scan_result_t got;
    scan_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {vram_address, status_byte, nmi_flag, new_frame, dot_position, line_position};
        if (awaited_results.size() == 0) begin
          err_count++;
          if (err_count <= 10) $display("%0t: result with nothing awaited: %p", $realtime, got);
        end else begin
          want = awaited_results.pop_front();
          checked_count++;
          if (want.new_frame) frames_seen++;
          if (want.nmi_flag) nmi_seen++;
          if (got.vram_address !== want.vram_address || got.status_byte !== want.status_byte ||
              got.nmi_flag !== want.nmi_flag || got.new_frame !== want.new_frame ||
              got.dot_position !== want.dot_position ||
              got.line_position !== want.line_position) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch exp/got addr %h/%h status %h/%h nmi %b/%b ",
                        "frame %b/%b dot %0d/%0d line %0d/%0d"}, $realtime,
                       want.vram_address, got.vram_address, want.status_byte, got.status_byte,
                       want.nmi_flag, got.nmi_flag, want.new_frame, got.new_frame,
                       want.dot_position, got.dot_position,
                       $signed(want.line_position), $signed(got.line_position));
          end
        end
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(next_scan_result(mode_e'(in_mode), in_value));
        accepted_count++;
      end
    end
  end

  task automatic push(mode_e m, logic [7:0] v);
    pending_items.push_back('{m, v});
    pushed_count++;
    if (m == MODE_TICK) tick_count++;
    if (m == MODE_DATA) data_count++;
  endtask

  task automatic wait_drained();
    while (accepted_count != pushed_count) @(negedge clk);
  endtask

  // Queue one short sequence: mostly well-formed register traffic, some noise
  task automatic add_random_sequence();
    case ($urandom_range(0, 9))
      0, 1: repeat ($urandom_range(1, 24)) push(MODE_TICK, 8'($urandom));
      2: push(MODE_CTRL, 8'($urandom));
      3: push(MODE_MASK, 8'($urandom));
      4: begin
        push(MODE_STATUS, 8'($urandom));
        push(MODE_SCROLL, 8'($urandom));
        push(MODE_SCROLL, 8'($urandom));
      end
      5: begin
        push(MODE_STATUS, 8'($urandom));
        push(MODE_ADDR, 8'($urandom));
        push(MODE_ADDR, 8'($urandom));
        repeat ($urandom_range(1, 4)) push(MODE_DATA, 8'($urandom));
      end
      6: repeat ($urandom_range(1, 3)) push(MODE_DATA, 8'($urandom));
      7: push(MODE_POLL, 8'($urandom));
      8: push(MODE_STATUS, 8'($urandom));
      default: push(mode_e'($urandom_range(0, 7)), 8'($urandom));
    endcase
  endtask

  // Tick up to a scan position, optionally mixing in register traffic
  task automatic tick_to(int ln, int dt, bit mixed);
    int d;
    forever begin
      wait_drained();
      d = (pos_index(ln, dt) - pos_index(scan_line(), dot_cnt) + FRAME_SPAN) % FRAME_SPAN;
      // stop on target, or one past it after a skipped dot
      if (d == 0 || d > FRAME_SPAN - 4) break;
      if (mixed && d > BATCH && $urandom_range(0, 23) == 0) add_random_sequence();
      repeat ((d > BATCH) ? BATCH : d) push(MODE_TICK, 8'($urandom));
    end
  endtask

  // Load the temporary address with all ones and turn rendering on
  task automatic load_full_scroll();
    push(MODE_STATUS, 8'h00);
    push(MODE_SCROLL, 8'hFF);
    push(MODE_SCROLL, 8'hFF);
    push(MODE_CTRL, 8'h87);
    push(MODE_MASK, 8'h18);
  endtask

  initial begin : stimulus
    int base;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // NMI on control writes while vblank is up from reset
    push(MODE_CTRL, 8'h80);
    push(MODE_POLL, 8'hFF);
    push(MODE_POLL, 8'h00);
    push(MODE_CTRL, 8'h00);
    push(MODE_CTRL, 8'hFF);
    push(MODE_CTRL, 8'hFF);
    push(MODE_POLL, 8'hFF);
    push(MODE_STATUS, 8'hFF);
    push(MODE_STATUS, 8'h00);
    push(MODE_CTRL, 8'h00);
    push(MODE_CTRL, 8'h80);
    push(MODE_POLL, 8'h00);
    // write latch, reset by a status read; high address write drops bit 14
    push(MODE_SCROLL, 8'hFF);
    push(MODE_STATUS, 8'h00);
    push(MODE_SCROLL, 8'h00);
    push(MODE_SCROLL, 8'hFF);
    push(MODE_ADDR, 8'hFF);
    push(MODE_ADDR, 8'hFF);
    push(MODE_CTRL, 8'h00);
    push(MODE_DATA, 8'hFF);
    push(MODE_DATA, 8'h00);
    push(MODE_CTRL, 8'h04);
    push(MODE_DATA, 8'hFF);
    push(MODE_DATA, 8'h00);
    push(MODE_ADDR, 8'h00);
    push(MODE_ADDR, 8'h00);
    push(MODE_MASK, 8'hFF);
    push(MODE_TICK, 8'hFF);
    push(MODE_MASK, 8'h00);
    push(MODE_TICK, 8'h00);
    wait_drained();

    // Random traffic with a long hold-off on the result side
    stall_go = 1'b1;
    base = pushed_count;
    while (pushed_count - base < 550) add_random_sequence();

    // Run the first frame into vblank with rendering on
    push(MODE_MASK, 8'h18);
    tick_to(240, 300, 1'b1);
    push(MODE_CTRL, 8'h80);
    push(MODE_MASK, 8'h18);
    tick_to(241, 3, 1'b0);
    push(MODE_POLL, 8'h00);
    push(MODE_CTRL, 8'h00);
    push(MODE_CTRL, 8'h80);
    push(MODE_POLL, 8'h00);
    push(MODE_STATUS, 8'h00);
    push(MODE_STATUS, 8'h00);
    push(MODE_POLL, 8'h00);
    tick_to(260, 300, 1'b1);

    // Cross the frame end; vertical copy yields an address at the top of the range
    load_full_scroll();
    push(MODE_CTRL, 8'h80);
    push(MODE_CTRL, 8'h87);
    tick_to(-1, 310, 1'b0);
    push(MODE_POLL, 8'h00);
    push(MODE_STATUS, 8'h00);
    repeat (3) push(MODE_DATA, 8'($urandom));
    tick_to(0, 5, 1'b0);

    // Second frame: line 0 without the skipped dot
    tick_to(-1, 330, 1'b1);
    push(MODE_MASK, 8'h08);
    tick_to(0, 5, 1'b0);

    // Finish with no idling on either side
    wait_drained();
    quiet = 1'b1;
    base = pushed_count;
    while (pushed_count - base < 60) add_random_sequence();

    wait_drained();
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    err_count += awaited_results.size();

    $display("ran %0d items (%0d ticks, %0d data accesses), checked %0d results",
             pushed_count, tick_count, data_count, checked_count);
    $display("saw %0d vblank entries and %0d NMIs through two frame wraps",
             frames_seen, nmi_seen);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Stop a hung run
  initial begin : watchdog
    #40_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
